@@ hw/rtl/srrw_pkg.sv @@
// Shared types for the selective-repeat receive window: frame and result
// payloads, frame kinds, controller states and the command/status bundles.
// No dependencies.
`default_nettype none

package srrw_pkg;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [3:0]  frame_id;
    logic [15:0] total_frames;
    logic        frame_ok;
    logic        reply_allowed;
  } frame_t;

  typedef struct packed {
    logic       ack_send;
    logic       ack_all;
    logic [3:0] ack_number;
    logic       transfer_done;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {
    KIND_SYN = 2'd0,
    KIND_PKT = 2'd1,
    KIND_ACK = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_DECODE,
    ST_RELEASE,
    ST_ACK_PREV,
    ST_ACK_EXP,
    ST_FINISH,
    ST_ACK_ALL
  } state_e;

  typedef enum logic [1:0] {
    RES_ALL,
    RES_PREV,
    RES_EXP,
    RES_FIN
  } res_sel_e;

  typedef struct packed {
    logic     capture;
    logic     syn_load;
    logic     step;
    logic     mark;
    logic     go_idle;
    logic     load;
    res_sel_e res_sel;
    logic     last;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic is_syn;
    logic mode;
    logic in_order;
    logic exp_buffered;
    logic done;
    logic reply;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/srrw_dp.sv @@
// Datapath of the selective-repeat receive window: frame capture, window
// state, buffered-slot bitmap and the output register.
// Depends on srrw_pkg.
`default_nettype none

module srrw_dp import srrw_pkg::*; #(
  parameter int unsigned WINDOW_SIZE = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire frame_t  in_frame_i,
  input  wire cmd_t    cmd_i,
  output status_t      status_o,
  input  wire logic    out_ready_i,
  output logic         out_valid_o,
  output result_t      out_result_o
);

  localparam int unsigned SW        = $clog2(WINDOW_SIZE);
  // Frame ids are 4 bits wide, so no slot above 15 can ever be buffered.
  localparam int unsigned BUF_DEPTH = (WINDOW_SIZE < 16) ? WINDOW_SIZE : 16;
  localparam int unsigned BW        = $clog2(BUF_DEPTH);
  localparam int unsigned CW        = (SW > 4) ? SW : 4;
  localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW_SIZE - 1);

  frame_t               frame_q;
  logic                 mode_q, mode_d;
  logic [SW-1:0]        exp_q, exp_d;
  logic [15:0]          cnt_q, cnt_d;
  logic [15:0]          total_q, total_d;
  logic [BUF_DEPTH-1:0] buf_q, buf_d;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q, out_d;

  logic [SW-1:0] exp_next, exp_prev;
  logic          exp_in_buf, id_in_window, in_order;
  result_t       res;

  assign exp_next     = (exp_q == LAST_SLOT) ? '0 : exp_q + SW'(1);
  assign exp_prev     = (exp_q == '0) ? LAST_SLOT : exp_q - SW'(1);
  assign exp_in_buf   = 32'(exp_q) < BUF_DEPTH;
  assign id_in_window = 32'(frame_q.frame_id) < WINDOW_SIZE;
  assign in_order     = CW'(frame_q.frame_id) == CW'(exp_q);

  always_comb begin
    status_o              = '0;
    status_o.mode         = mode_q;
    status_o.is_syn       = frame_q.frame_kind == KIND_SYN;
    status_o.in_order     = in_order;
    status_o.exp_buffered = exp_in_buf && buf_q[exp_q[BW-1:0]];
    status_o.done         = cnt_q == total_q;
    status_o.reply        = frame_q.reply_allowed;
    status_o.out_free     = !out_valid_q || out_ready_i;
    if (!frame_q.frame_ok) begin
      status_o.drop = 1'b1;
    end else if (!mode_q) begin
      status_o.drop = (frame_q.frame_kind != KIND_SYN) && (frame_q.frame_kind != KIND_PKT);
    end else begin
      status_o.drop = (frame_q.frame_kind != KIND_PKT) || !id_in_window;
    end
  end

  always_comb begin
    mode_d  = mode_q;
    exp_d   = exp_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    buf_d   = buf_q;
    if (cmd_i.syn_load) begin
      mode_d  = 1'b1;
      exp_d   = '0;
      cnt_d   = '0;
      total_d = frame_q.total_frames;
      buf_d   = '0;
    end
    // Stepping clears the expected slot's buffered bit, counts a delivery and advances the slot.
    if (cmd_i.step) begin
      if (exp_in_buf) begin
        buf_d[exp_q[BW-1:0]] = 1'b0;
      end
      cnt_d = cnt_q + 16'd1;
      exp_d = exp_next;
    end
    if (cmd_i.mark) begin
      buf_d[frame_q.frame_id[BW-1:0]] = 1'b1;
    end
    if (cmd_i.go_idle) begin
      mode_d = 1'b0;
    end
  end

  always_comb begin
    res      = '0;
    res.last = cmd_i.last;
    case (cmd_i.res_sel)
      RES_ALL: begin
        res.ack_send = 1'b1;
        res.ack_all  = 1'b1;
      end
      RES_PREV: begin
        res.ack_send   = 1'b1;
        res.ack_number = 4'(exp_prev);
      end
      RES_EXP: begin
        res.ack_send   = 1'b1;
        res.ack_number = 4'(exp_q);
      end
      RES_FIN: begin
        res.ack_send      = frame_q.reply_allowed;
        res.ack_all       = 1'b1;
        res.transfer_done = 1'b1;
      end
      default: res = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      exp_q       <= '0;
      cnt_q       <= '0;
      total_q     <= '0;
      buf_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      exp_q       <= exp_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      buf_q       <= buf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      frame_q <= in_frame_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending one");
  a_step_receiving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> mode_q)
    else $error("window advanced while idle");
  a_mark_not_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark |-> !in_order)
    else $error("expected slot marked as buffered");
  a_syn_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.syn_load |=> (mode_q && buf_q == '0 && cnt_q == '0))
    else $error("SYN did not reset the window");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/srrw_ctrl.sv @@
// Controller of the selective-repeat receive window: sequences capture,
// decode, slot release and result emission.
// Depends on srrw_pkg.
`default_nettype none

module srrw_ctrl import srrw_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_WAIT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.drop) begin
          state_d = ST_WAIT;
        end else if (!status_i.mode) begin
          cmd_o.syn_load = status_i.is_syn;
          state_d        = status_i.reply ? ST_ACK_ALL : ST_WAIT;
        end else if (status_i.in_order) begin
          cmd_o.step = 1'b1;
          state_d    = ST_RELEASE;
        end else begin
          cmd_o.mark = 1'b1;
          state_d    = ST_ACK_EXP;
        end
      end
      ST_RELEASE: begin
        // Release one buffered slot per cycle.
        if (status_i.exp_buffered) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = ST_ACK_PREV;
        end
      end
      ST_ACK_PREV, ST_ACK_EXP: begin
        if (!status_i.reply) begin
          state_d = status_i.done ? ST_FINISH : ST_WAIT;
        end else if (status_i.out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.res_sel = (state_q == ST_ACK_PREV) ? RES_PREV : RES_EXP;
          cmd_o.last    = !status_i.done;
          state_d       = status_i.done ? ST_FINISH : ST_WAIT;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.res_sel = RES_FIN;
          cmd_o.last    = 1'b1;
          cmd_o.go_idle = 1'b1;
          state_d       = ST_WAIT;
        end
      end
      ST_ACK_ALL: begin
        if (status_i.out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.res_sel = RES_ALL;
          cmd_o.last    = 1'b1;
          state_d       = ST_WAIT;
        end
      end
      default: state_d = ST_WAIT;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/selective_repeat_receive_window.sv @@
// Flow: a dropped frame goes from decode straight back to waiting; otherwise the result
// register loads from an ACK state, which an in-order PKT reaches through the release
// loop, and a transfer-done result loads from the finish state after that.
// A new frame is accepted only while waiting, once the last one is fully handled; the release
// loop walks one buffered slot per cycle, and each result waits for room in the full output
// register. Reset: window cleared.
`default_nettype none

module selective_repeat_receive_window import srrw_pkg::*; #(
  parameter int unsigned WINDOW_SIZE = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire frame_t in_frame_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output result_t     out_result_o
);

  // Command and status bundles between controller and datapath.
  cmd_t    cmd;
  status_t status;

  // Controller: hold off new transactions while a frame is being worked on,
  // advance through release and emit the ACK and transfer-done results.
  srrw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: window state, buffered-slot bitmap and the output register
  // that holds a result until the downstream side takes it.
  srrw_dp #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_frame_i   (in_frame_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_result_o (out_result_o)
  );

endmodule

`default_nettype wire

@@ tb/tb_selective_repeat_receive_window.sv @@
// Self-checking testbench for selective_repeat_receive_window: a directed table of frames,
// then random transfers, checked against a built-in model of the receive window.
// Depends on srrw_pkg and the selective_repeat_receive_window RTL.

module tb_selective_repeat_receive_window;
  import srrw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW = 16;             // window size equals the 4-bit slot range
  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam int RANDOM_UNTIL = 1250;     // frames sent before the calm tail starts
  localparam int TOTAL_FRAMES = 1550;
  localparam int HOLD_CYCLES = 300;       // long output hold-off that backs up the input
  localparam int DRAIN_CYCLES = 2 * (WINDOW + 4);
  // Slowest transaction: a sender gap plus a window release plus a receiver stall, twice
  // over for two results per frame, is far below this; the hold-off dominates.
  localparam int WATCHDOG_LIMIT = 10 * HOLD_CYCLES;

  localparam result_t NO_RES = '0;
  localparam result_t ACK_ALL_LAST = '{1'b1, 1'b1, 4'd0, 1'b0, 1'b1};

  typedef struct packed {
    frame_t     frame;
    logic       typed;     // 1: expected results are given in the row itself
    logic [1:0] n_typed;
    result_t    r0;
    result_t    r1;
  } dir_row_t;

  // Directed frames. Rows with typed results read straight off the protocol; the
  // last rows leave a transfer open for the random part and use the window model.
  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    // idle: PKT gets ACK(-1), or nothing when replies are off
    '{'{KIND_PKT, 4'd0, 16'h0000, 1'b1, 1'b1}, 1'b1, 2'd1, ACK_ALL_LAST, NO_RES},
    '{'{KIND_PKT, 4'd15, 16'hFFFF, 1'b1, 1'b0}, 1'b1, 2'd0, NO_RES, NO_RES},
    // idle: ACK and reserved kinds drop, as does a SYN that failed its check
    '{'{KIND_ACK, 4'hA, 16'h5555, 1'b1, 1'b1}, 1'b1, 2'd0, NO_RES, NO_RES},
    '{'{KIND_RESERVED, 4'h5, 16'hAAAA, 1'b1, 1'b1}, 1'b1, 2'd0, NO_RES, NO_RES},
    '{'{KIND_SYN, 4'd0, 16'hFFFF, 1'b0, 1'b1}, 1'b1, 2'd0, NO_RES, NO_RES},
    // empty transfer: SYN with zero frames
    '{'{KIND_SYN, 4'd0, 16'h0000, 1'b1, 1'b1}, 1'b1, 2'd1, ACK_ALL_LAST, NO_RES},
    // receiving: SYN, ACK, reserved kind and a bad PKT all drop
    '{'{KIND_SYN, 4'd0, 16'd7, 1'b1, 1'b1}, 1'b1, 2'd0, NO_RES, NO_RES},
    '{'{KIND_ACK, 4'd3, 16'd0, 1'b1, 1'b1}, 1'b1, 2'd0, NO_RES, NO_RES},
    '{'{KIND_RESERVED, 4'd0, 16'd0, 1'b1, 1'b1}, 1'b1, 2'd0, NO_RES, NO_RES},
    '{'{KIND_PKT, 4'd0, 16'd0, 1'b0, 1'b1}, 1'b1, 2'd0, NO_RES, NO_RES},
    // any PKT but the expected slot closes the empty transfer: slot ACK, then transfer done
    '{'{KIND_PKT, 4'd5, 16'd0, 1'b1, 1'b1}, 1'b1, 2'd2,
      '{1'b1, 1'b0, 4'd0, 1'b0, 1'b0}, '{1'b1, 1'b1, 4'd0, 1'b1, 1'b1}},
    // three-frame transfer, out of order, with a duplicate and a silent in-order frame
    '{'{KIND_SYN, 4'd9, 16'd3, 1'b1, 1'b0}, 1'b1, 2'd0, NO_RES, NO_RES},
    '{'{KIND_PKT, 4'd2, 16'd0, 1'b1, 1'b1}, 1'b1, 2'd1, '{1'b1, 1'b0, 4'd0, 1'b0, 1'b1}, NO_RES},
    '{'{KIND_PKT, 4'd2, 16'd0, 1'b1, 1'b1}, 1'b1, 2'd1, '{1'b1, 1'b0, 4'd0, 1'b0, 1'b1}, NO_RES},
    '{'{KIND_PKT, 4'd0, 16'd0, 1'b1, 1'b0}, 1'b1, 2'd0, NO_RES, NO_RES},
    '{'{KIND_PKT, 4'd1, 16'd0, 1'b1, 1'b1}, 1'b1, 2'd2,
      '{1'b1, 1'b0, 4'd2, 1'b0, 1'b0}, '{1'b1, 1'b1, 4'd0, 1'b1, 1'b1}},
    // one-frame transfer finishing with replies off: done still reported
    '{'{KIND_SYN, 4'd0, 16'd1, 1'b1, 1'b1}, 1'b1, 2'd1, ACK_ALL_LAST, NO_RES},
    '{'{KIND_PKT, 4'd0, 16'd0, 1'b1, 1'b0}, 1'b1, 2'd1, '{1'b0, 1'b1, 4'd0, 1'b1, 1'b1}, NO_RES},
    // open a transfer and leave it running: far slot, in order, stale slot, far slot, in order
    '{'{KIND_SYN, 4'd0, 16'd20, 1'b1, 1'b1}, 1'b1, 2'd1, ACK_ALL_LAST, NO_RES},
    '{'{KIND_PKT, 4'd15, 16'd0, 1'b1, 1'b1}, 1'b0, 2'd0, NO_RES, NO_RES},
    '{'{KIND_PKT, 4'd0, 16'd0, 1'b1, 1'b1}, 1'b0, 2'd0, NO_RES, NO_RES},
    '{'{KIND_PKT, 4'd0, 16'd0, 1'b1, 1'b1}, 1'b0, 2'd0, NO_RES, NO_RES},
    '{'{KIND_PKT, 4'd14, 16'd0, 1'b1, 1'b0}, 1'b0, 2'd0, NO_RES, NO_RES},
    '{'{KIND_PKT, 4'd1, 16'd0, 1'b1, 1'b1}, 1'b0, 2'd0, NO_RES, NO_RES}
  };

  logic    clk_i;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_ready_o;
  frame_t  in_frame_i = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  result_t out_result_o;

  // Window model state, advanced at each accepted input transaction.
  logic              rx_active = 1'b0;
  logic [3:0]        exp_slot = '0;
  logic [15:0]       delivered = '0;
  logic [15:0]       announced = '0;
  logic [WINDOW-1:0] held = '0;

  result_t ack_expect [$];   // ACK results still owed by the block, oldest first
  result_t ack_want;
  int      mismatches = 0;
  int      frames_sent = 0;
  int      stall_cycles = 0;
  bit      calm = 1'b0;      // tail of the run: no idling on either side
  bit      tx_lazy = 1'b1;   // sender may insert gaps
  bit      hold_req = 1'b0;  // ask the receiver for one long hold-off

  selective_repeat_receive_window #(
    .WINDOW_SIZE(WINDOW)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_frame_i  (in_frame_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_result_o(out_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic result_t make_ack(input logic send, input logic all,
                                       input logic [3:0] num, input logic done);
    result_t r;
    r = '{send, all, num, done, 1'b0};
    return r;
  endfunction

  // Advance the window model by one frame and return the ACKs it causes.
  function automatic void window_step(input frame_t f, output int n,
                                      output result_t r0, output result_t r1);
    result_t res [2];
    int      steps;
    logic [3:0] ack_no;
    res[0] = NO_RES;
    res[1] = NO_RES;
    n = 0;
    if (f.frame_ok) begin
      if (!rx_active) begin
        if (f.frame_kind == KIND_SYN) begin
          // Start a transfer: clear the window and load the frame count.
          exp_slot = '0;
          delivered = '0;
          held = '0;
          announced = f.total_frames;
          rx_active = 1'b1;
          if (f.reply_allowed) begin
            res[n] = make_ack(1'b1, 1'b1, 4'd0, 1'b0);
            n++;
          end
        end else if (f.frame_kind == KIND_PKT && f.reply_allowed) begin
          res[n] = make_ack(1'b1, 1'b1, 4'd0, 1'b0);
          n++;
        end
      end else if (f.frame_kind == KIND_PKT && f.frame_id < WINDOW) begin
        if (f.frame_id == exp_slot) begin
          // Deliver this slot, then release the run of buffered slots behind it.
          delivered = delivered + 16'd1;
          exp_slot = 4'((exp_slot + 1) % WINDOW);
          steps = 0;
          while (steps < WINDOW && held[exp_slot]) begin
            held[exp_slot] = 1'b0;
            delivered = delivered + 16'd1;
            exp_slot = 4'((exp_slot + 1) % WINDOW);
            steps++;
          end
          ack_no = 4'((exp_slot + WINDOW - 1) % WINDOW);
          if (f.reply_allowed) begin
            res[n] = make_ack(1'b1, 1'b0, ack_no, 1'b0);
            n++;
          end
        end else begin
          held[f.frame_id] = 1'b1;
          if (f.reply_allowed) begin
            res[n] = make_ack(1'b1, 1'b0, exp_slot, 1'b0);
            n++;
          end
        end
        if (delivered == announced) begin
          rx_active = 1'b0;
          res[n] = make_ack(f.reply_allowed, 1'b1, 4'd0, 1'b1);
          n++;
        end
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    r0 = res[0];
    r1 = res[1];
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] %s", $time, what);
    mismatches++;
  endtask

  // Offer one frame, hold it until accepted, then queue the ACKs it owes.
  task automatic send_frame(input frame_t f, input logic typed, input int n_typed,
                            input result_t t0, input result_t t1);
    int      n;
    result_t p0;
    result_t p1;
    if (!calm && tx_lazy && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_frame_i <= f;
    do @(posedge clk_i); while (!in_ready_o);
    frames_sent++;
    window_step(f, n, p0, p1);
    if (typed) begin
      n = n_typed;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) ack_expect = {ack_expect, p0};
    if (n > 1) ack_expect = {ack_expect, p1};
  endtask

  task automatic send_pkt(input logic [3:0] id);
    frame_t f;
    f.frame_kind = KIND_PKT;
    f.frame_id = id;
    f.total_frames = 16'($urandom());
    f.frame_ok = 1'b1;
    f.reply_allowed = $urandom_range(0, 7) != 0;
    send_frame(f, 1'b0, 0, NO_RES, NO_RES);
  endtask

  task automatic open_transfer(input logic [15:0] total);
    frame_t f;
    f.frame_kind = KIND_SYN;
    f.frame_id = 4'($urandom());
    f.total_frames = total;
    f.frame_ok = 1'b1;
    f.reply_allowed = $urandom_range(0, 5) != 0;
    send_frame(f, 1'b0, 0, NO_RES, NO_RES);
  endtask

  // Random frame that cannot disturb an open transfer: in receiving, a PKT that
  // would be taken is turned into a bad frame; in idle, a SYN announces few frames.
  function automatic frame_t noise_frame();
    frame_t f;
    f = 24'($urandom());
    if (rx_active && f.frame_kind == KIND_PKT) f.frame_ok = 1'b0;
    if (!rx_active && f.frame_kind == KIND_SYN && f.frame_ok)
      f.total_frames = 16'($urandom_range(0, 40));
    return f;
  endfunction

  // Send up to one window's worth of slots starting at the expected one, in shuffled,
  // reversed or natural order, with noise and repeats mixed in. The span is kept
  // small enough that deliveries never run past the announced total.
  task automatic run_chunk();
    logic [3:0] plan [$];
    logic [3:0] sent [$];
    logic [3:0] slot;
    int remaining;
    int span;
    int outside;
    int margin;
    remaining = int'(announced) - int'(delivered);
    tx_lazy = $urandom_range(0, 2) != 0;
    if (remaining == 0) begin
      // Empty transfer: any slot but the expected one closes it.
      send_pkt(4'(exp_slot + 1));
      return;
    end
    span = $urandom_range(1, WINDOW);
    forever begin
      outside = 0;
      for (int k = span; k < WINDOW; k++) outside += int'(held[(exp_slot + k) % WINDOW]);
      if (span == 1 || span + outside <= remaining) break;
      span--;
    end
    for (int k = 0; k < span; k++) begin
      slot = 4'((exp_slot + k) % WINDOW);
      if (!held[slot]) plan = {plan, slot};
    end
    case ($urandom_range(0, 3))
      0: plan.reverse();
      1: ;
      default: plan.shuffle();
    endcase
    foreach (plan[i]) begin
      if (!rx_active) break;
      if ($urandom_range(0, 19) == 0) send_frame(noise_frame(), 1'b0, 0, NO_RES, NO_RES);
      // A repeat of a delivered slot buffers it again and adds a delivery later:
      // allow it only while there is room left before the announced total.
      margin = int'(announced) - int'(delivered) - (plan.size() - i) - $countones(held);
      if (sent.size() != 0 && margin >= 2 && $urandom_range(0, 12) == 0)
        send_pkt(sent[$urandom_range(0, sent.size() - 1)]);
      send_pkt(plan[i]);
      sent = {sent, plan[i]};
    end
  endtask

  // Receiver: accept results with random stall bursts, plus the requested hold-off.
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Check every output transaction against the oldest owed ACK, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (ack_expect.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %p", out_result_o));
      end else begin
        ack_want = ack_expect.pop_front();
        if (out_result_o.ack_send !== ack_want.ack_send)
          flag_mismatch($sformatf("ack_send %b, want %b",
                                  out_result_o.ack_send, ack_want.ack_send));
        if (out_result_o.ack_all !== ack_want.ack_all)
          flag_mismatch($sformatf("ack_all %b, want %b",
                                  out_result_o.ack_all, ack_want.ack_all));
        if (out_result_o.ack_number !== ack_want.ack_number)
          flag_mismatch($sformatf("ack_number %0d, want %0d",
                                  out_result_o.ack_number, ack_want.ack_number));
        if (out_result_o.transfer_done !== ack_want.transfer_done)
          flag_mismatch($sformatf("transfer_done %b, want %b",
                                  out_result_o.transfer_done, ack_want.transfer_done));
        if (out_result_o.last !== ack_want.last)
          flag_mismatch($sformatf("last %b, want %b",
                                  out_result_o.last, ack_want.last));
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("selective_repeat_receive_window: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int holds_done;
    logic [15:0] total;
    holds_done = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++)
      send_frame(DIR_TABLE[i].frame, DIR_TABLE[i].typed, int'(DIR_TABLE[i].n_typed),
                 DIR_TABLE[i].r0, DIR_TABLE[i].r1);

    // Random part: mostly well-formed transfers, some noise between them.
    while (frames_sent < RANDOM_UNTIL) begin
      // Twice, stop the receiver for a long stretch while frames keep coming.
      if (holds_done < 2 && frames_sent >= 400 * (holds_done + 1)) begin
        hold_req = 1'b1;
        holds_done++;
      end
      if ($urandom_range(0, 9) == 0) begin
        tx_lazy = 1'b1;
        send_frame(noise_frame(), 1'b0, 0, NO_RES, NO_RES);
      end else if (!rx_active) begin
        case ($urandom_range(0, 19))
          0: total = 16'd0;
          1, 2, 3, 4: total = 16'($urandom_range(41, 120));
          default: total = 16'($urandom_range(1, 40));
        endcase
        open_transfer(total);
      end else begin
        run_chunk();
      end
    end

    // Calm tail: finish the open transfer, then one long transfer with a large count.
    calm = 1'b1;
    while (rx_active && frames_sent < TOTAL_FRAMES - 100) run_chunk();
    if (!rx_active) open_transfer(16'($urandom_range(32768, 65535)));
    while (frames_sent < TOTAL_FRAMES) begin
      if (rx_active) run_chunk();
      else send_frame(noise_frame(), 1'b0, 0, NO_RES, NO_RES);
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every owed ACK, then watch a while for strays.
    while (ack_expect.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("selective_repeat_receive_window: match");
    end else begin
      $display("selective_repeat_receive_window: mismatch");
    end
    $finish;
  end

endmodule
